FILE: rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  // Pool geometry
  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned SLOT_COUNT   = POOL_BYTES / 4;
  localparam int unsigned SLOT_W       = $clog2(SLOT_COUNT);   // header slot index
  localparam int unsigned LINK_W       = SLOT_W + 1;           // slot index or null mark
  localparam int unsigned POOL_W       = $clog2(POOL_BYTES);   // byte offset
  localparam int unsigned SIZE_W       = 13;                   // stored payload size
  localparam int unsigned REQ_W        = 13;                   // request size field
  localparam int unsigned NEED_W       = REQ_W + 1;            // rounded request
  localparam int unsigned REM_W        = NEED_W + 1;           // split arithmetic
  localparam int unsigned VISIT_W      = SLOT_W + 1;

  localparam logic [LINK_W-1:0] NULL_SLOT  = LINK_W'(SLOT_COUNT);
  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(POOL_BYTES - HEADER_BYTES);

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [REQ_W-1:0]  req_size;
    logic [POOL_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [POOL_W-1:0] result_addr;
    logic              granted;
  } rsp_t;

  // Header store access from the control FSM
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              sz_we;
    logic [SLOT_W-1:0] sz_slot;
    logic [SIZE_W-1:0] sz_data;
    logic              nx_we;
    logic [SLOT_W-1:0] nx_slot;
    logic [LINK_W-1:0] nx_data;
  } hdr_req_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [LINK_W-1:0] next;
  } hdr_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_READ,
    ST_CHECK,
    ST_SPLIT,
    ST_LINK,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/ffa_hdr_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Header size and link memories with a registered synchronous read.
// Slot 0 reads its reset contents until it is first written.
module ffa_hdr_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffa_pkg::hdr_req_t req_i,
  output ffa_pkg::hdr_rd_t  rdata_o
);
  import ffa_pkg::*;

  logic [SIZE_W-1:0] size_mem [SLOT_COUNT];
  logic [LINK_W-1:0] next_mem [SLOT_COUNT];

  logic [SIZE_W-1:0] size_rd_q;
  logic [LINK_W-1:0] next_rd_q;
  logic              sz0_wr_q, nx0_wr_q;
  logic              sz_fresh_q, nx_fresh_q;

  always_ff @(posedge clk_i) begin
    if (req_i.sz_we) begin
      size_mem[req_i.sz_slot] <= req_i.sz_data;
    end
    if (req_i.nx_we) begin
      next_mem[req_i.nx_slot] <= req_i.nx_data;
    end
    if (req_i.rd_en) begin
      size_rd_q <= size_mem[req_i.rd_slot];
      next_rd_q <= next_mem[req_i.rd_slot];
    end
  end

  // Track first write to slot 0 and whether the last read saw it unwritten
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sz0_wr_q   <= 1'b0;
      nx0_wr_q   <= 1'b0;
      sz_fresh_q <= 1'b0;
      nx_fresh_q <= 1'b0;
    end else begin
      if (req_i.sz_we && (req_i.sz_slot == '0)) begin
        sz0_wr_q <= 1'b1;
      end
      if (req_i.nx_we && (req_i.nx_slot == '0)) begin
        nx0_wr_q <= 1'b1;
      end
      if (req_i.rd_en) begin
        sz_fresh_q <= (req_i.rd_slot == '0) && !sz0_wr_q;
        nx_fresh_q <= (req_i.rd_slot == '0) && !nx0_wr_q;
      end
    end
  end

  assign rdata_o.size = sz_fresh_q ? RESET_SIZE : size_rd_q;
  assign rdata_o.next = nx_fresh_q ? NULL_SLOT  : next_rd_q;

endmodule

`default_nettype wire

FILE: rtl/core/first_fit_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake             | Word
// --------+-----------+-----------------------+--------------------------------------
// in      | input     | in_valid_i/in_ready_o  | in_word_i  {func, req_size, block_addr}
// out     | output    | out_valid_o/out_ready_i| out_word_o {result_addr, granted}
//
// Free: accept, link write, result; bad free or zero size: accept, result.
// Allocate: accept, header read and compare per block visited on the one read
// port, a split write (on a split) and a link write on a fit, then a result.
// Reset: head at slot 0, which reads its reset header until first written, so
// no clearing pass. Stalls: the result register holds while out_ready_i is
// low; the next word is accepted and waits behind it.
module first_fit_free_list_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffa_pkg::req_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ffa_pkg::rsp_t out_word_o
);
  import ffa_pkg::*;

  state_e state_q, state_d;

  logic [LINK_W-1:0]  head_q;
  logic [LINK_W-1:0]  cur_q, prev_q;
  logic [VISIT_W-1:0] visits_q;
  logic [NEED_W-1:0]  need_q;
  logic [SLOT_W-1:0]  free_slot_q;
  logic [SLOT_W-1:0]  rem_slot_q;
  logic [SIZE_W-1:0]  rem_size_q;
  logic [LINK_W-1:0]  nxt_q;
  logic [LINK_W-1:0]  link_tgt_q;
  logic               split_q;
  rsp_t               res_q;
  rsp_t               out_q;
  logic               out_valid_q;

  hdr_req_t hdr_req;
  hdr_rd_t  hdr_rd;

  logic in_fire;
  logic out_free;

  // Request decode at acceptance
  logic [NEED_W-1:0] need_in;
  logic [POOL_W-1:0] hdr_off;
  logic              free_ok;

  // Fit test on the header just read
  logic              fits;
  logic              can_split;
  logic [REM_W-1:0]  rem_off;
  logic [REM_W-1:0]  split_need;
  logic [POOL_W-1:0] pay_addr;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign need_in = (NEED_W'(in_word_i.req_size) + NEED_W'(3)) & ~NEED_W'(3);
  assign hdr_off = in_word_i.block_addr - POOL_W'(HEADER_BYTES);
  assign free_ok = (in_word_i.block_addr >= POOL_W'(HEADER_BYTES))
                && (in_word_i.block_addr[1:0] == 2'b00)
                && (hdr_off[1:0] == 2'b00)
                && ({1'b0, hdr_off} < (POOL_W + 1)'(POOL_BYTES));

  assign fits       = REM_W'(hdr_rd.size) >= REM_W'(need_q);
  assign split_need = REM_W'(need_q) + REM_W'(HEADER_BYTES + 4);
  assign rem_off    = REM_W'({cur_q[SLOT_W-1:0], 2'b00})
                    + REM_W'(HEADER_BYTES) + REM_W'(need_q);
  assign can_split  = (REM_W'(hdr_rd.size) >= split_need)
                   && (rem_off < REM_W'(POOL_BYTES));
  assign pay_addr   = {cur_q[SLOT_W-1:0], 2'b00} + POOL_W'(HEADER_BYTES);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_word_i.func == FUNC_FREE) begin
            state_d = free_ok ? ST_FREE : ST_RESP;
          end else begin
            state_d = (need_in == '0) ? ST_RESP : ST_READ;
          end
        end
      end
      ST_FREE: state_d = ST_RESP;
      ST_READ: begin
        if ((visits_q == VISIT_W'(SLOT_COUNT)) || (cur_q >= NULL_SLOT)) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!fits) begin
          state_d = ST_READ;
        end else begin
          state_d = can_split ? ST_SPLIT : ST_LINK;
        end
      end
      ST_SPLIT: state_d = ST_LINK;
      ST_LINK:  state_d = ST_RESP;
      ST_RESP:  state_d = out_free ? ST_IDLE : ST_RESP;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory requests and handshake outputs
  always_comb begin
    hdr_req    = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_FREE: begin
        // push the freed header onto the list head
        hdr_req.nx_we   = 1'b1;
        hdr_req.nx_slot = free_slot_q;
        hdr_req.nx_data = head_q;
      end
      ST_READ: begin
        hdr_req.rd_en   = (visits_q != VISIT_W'(SLOT_COUNT)) && (cur_q < NULL_SLOT);
        hdr_req.rd_slot = cur_q[SLOT_W-1:0];
      end
      ST_SPLIT: begin
        // remainder header inherits the taken block's link
        hdr_req.sz_we   = 1'b1;
        hdr_req.sz_slot = rem_slot_q;
        hdr_req.sz_data = rem_size_q;
        hdr_req.nx_we   = 1'b1;
        hdr_req.nx_slot = rem_slot_q;
        hdr_req.nx_data = nxt_q;
      end
      ST_LINK: begin
        hdr_req.sz_we   = split_q;
        hdr_req.sz_slot = cur_q[SLOT_W-1:0];
        hdr_req.sz_data = need_q[SIZE_W-1:0];
        hdr_req.nx_we   = (prev_q != NULL_SLOT);
        hdr_req.nx_slot = prev_q[SLOT_W-1:0];
        hdr_req.nx_data = link_tgt_q;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FREE) begin
        head_q <= LINK_W'(free_slot_q);
      end
      if ((state_q == ST_LINK) && (prev_q == NULL_SLOT)) begin
        head_q <= link_tgt_q;
      end
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk and result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        need_q      <= need_in;
        cur_q       <= head_q;
        prev_q      <= NULL_SLOT;
        visits_q    <= '0;
        free_slot_q <= hdr_off[POOL_W-1:2];
        res_q       <= '0;
      end
      ST_FREE: res_q.granted <= 1'b1;
      ST_CHECK: begin
        if (fits) begin
          rem_slot_q <= rem_off[POOL_W-1:2];
          rem_size_q <= SIZE_W'(REM_W'(hdr_rd.size) - REM_W'(need_q)
                                - REM_W'(HEADER_BYTES));
          nxt_q      <= hdr_rd.next;
          link_tgt_q <= hdr_rd.next;
          split_q    <= can_split;
        end else begin
          // advance along the list
          prev_q   <= cur_q;
          cur_q    <= hdr_rd.next;
          visits_q <= visits_q + VISIT_W'(1);
        end
      end
      ST_SPLIT: link_tgt_q <= LINK_W'(rem_slot_q);
      ST_LINK: begin
        res_q.granted     <= 1'b1;
        res_q.result_addr <= pay_addr;
      end
      ST_RESP: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  ffa_hdr_store u_hdr_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (hdr_req),
    .rdata_o (hdr_rd)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/ffa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ffa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ffa_pkg::req_t in_word_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ffa_pkg::rsp_t out_word_o
);
  import ffa_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // one word in flight: drop ready after an accept
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.granted |-> out_word_o.result_addr == '0)
    else $error("failed result carries an address");

  a_word_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.result_addr[1:0] == 2'b00)
    else $error("granted address not word aligned");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
